// ===== src/wfs_pkg.sv =====
// wfs_pkg: shared types and constants for the wavefront fetch scheduler.
// Used by wfs_ctrl, wfs_dp, wfs_checker and the top level; depends on nothing.
`default_nettype none

package wfs_pkg;

    // Fixed field widths of the stream words
    localparam int MASK_W     = 16;
    localparam int ID_OUT_W   = 4;
    localparam int STAMP_W    = 32;

    // Input tdata layout, lowest bit first
    localparam int ADD_ID_LSB = 0;
    localparam int RUN_LSB    = ADD_ID_LSB + ID_OUT_W;
    localparam int BUSY_LSB   = RUN_LSB + MASK_W;
    localparam int NOW_LSB    = BUSY_LSB + MASK_W;
    localparam int IN_USED_W  = NOW_LSB + STAMP_W;
    localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata: chosen id padded to a byte
    localparam int OUT_DATA_W = ((ID_OUT_W + 7) / 8) * 8;

    // Item kinds carried on tuser
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_SCHED = 1'b1;

    // Policy register codes
    localparam logic POL_RR     = 1'b0;
    localparam logic POL_GREEDY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RR,
        ST_REDUCE,
        ST_GR_DONE
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic ready;       // input side may take a word
        logic load_add;    // add word accepted
        logic load_sched;  // schedule word accepted
        logic reduce;      // one step of the greedy max tree
        logic commit_rr;   // write round-robin result
        logic commit_gr;   // write greedy result
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic in_mode;
        logic policy;
        logic out_free;
        logic reduce_last;
    } t_sts;

endpackage

`default_nettype wire

// ===== src/wfs_ctrl.sv =====
// wfs_ctrl: sequencing state machine for the wavefront fetch scheduler.
// Depends on wfs_pkg (t_state, t_cmd, t_sts).
`default_nettype none

module wfs_ctrl
    import wfs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_sts.in_valid) begin
                    if (i_sts.in_mode == MODE_ADD) begin
                        o_cmd.load_add = 1'b1;
                    end else begin
                        o_cmd.load_sched = 1'b1;
                        n_state = (i_sts.policy == POL_GREEDY) ? ST_REDUCE : ST_RR;
                    end
                end
            end
            ST_RR: begin
                if (i_sts.out_free) begin
                    o_cmd.commit_rr = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_REDUCE: begin
                o_cmd.reduce = 1'b1;
                if (i_sts.reduce_last) begin
                    n_state = ST_GR_DONE;
                end
            end
            ST_GR_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit_gr = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/wfs_dp.sv =====
// wfs_dp: pool mask, round-robin pointer, stamps, max tree and result register.
// Depends on wfs_pkg; driven by wfs_ctrl through t_cmd / t_sts.
`default_nettype none

module wfs_dp
    import wfs_pkg::*;
#(
    parameter int NUM_WAVEFRONTS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_mode,
    input  wire logic [IN_DATA_W-1:0]  i_in_data,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_data,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic                       o_out_found,
    output logic [ID_OUT_W-1:0]        o_out_id
);

    localparam int ID_W  = $clog2(NUM_WAVEFRONTS);
    localparam int SLOTS = 1 << ID_W;
    localparam int STEPS = (ID_W + 1) / 2;   // two tree levels per step
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    // input fields
    logic [ID_OUT_W-1:0] w_add_id;
    logic [MASK_W-1:0]   w_run;
    logic [MASK_W-1:0]   w_busy;
    logic [STAMP_W-1:0]  w_now;
    logic [NUM_WAVEFRONTS-1:0] w_elig;
    logic [SLOTS-1:0]    w_elig_pad;

    assign w_add_id = i_in_data[ADD_ID_LSB +: ID_OUT_W];
    assign w_run    = i_in_data[RUN_LSB +: MASK_W];
    assign w_busy   = i_in_data[BUSY_LSB +: MASK_W];
    assign w_now    = i_in_data[NOW_LSB +: STAMP_W];

    // state
    logic                      r_policy;
    logic [NUM_WAVEFRONTS-1:0] r_pool;
    logic [ID_W-1:0]           r_ptr;
    logic [STAMP_W-1:0]        r_stamp [NUM_WAVEFRONTS];

    // per-request working registers
    logic [NUM_WAVEFRONTS-1:0] r_elig;
    logic [STAMP_W-1:0]        r_now;
    logic                      r_sv  [SLOTS];
    logic [ID_W-1:0]           r_sid [SLOTS];
    logic [STAMP_W-1:0]        r_sst [SLOTS];
    logic [CNT_W-1:0]          r_cnt;

    logic                      r_out_valid;
    logic                      r_out_found;
    logic [ID_OUT_W-1:0]       r_out_id;

    logic [STAMP_W-1:0]        w_stamp_pad [SLOTS];

    // masks are 16 bits wide; ids past that are never eligible
    for (genvar g = 0; g < NUM_WAVEFRONTS; g++) begin : g_elig
        if (g < MASK_W) begin : g_in
            assign w_elig[g] = r_pool[g] & w_run[g] & ~w_busy[g];
        end else begin : g_out
            assign w_elig[g] = 1'b0;
        end
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_pad
        if (g < NUM_WAVEFRONTS) begin : g_real
            assign w_elig_pad[g]  = w_elig[g];
            assign w_stamp_pad[g] = r_stamp[g];
        end else begin : g_fill
            assign w_elig_pad[g]  = 1'b0;
            assign w_stamp_pad[g] = '0;
        end
    end

    // round-robin: first eligible at or above the pointer, else first overall
    logic            w_rr_hi_found;
    logic [ID_W-1:0] w_rr_hi;
    logic [ID_W-1:0] w_rr_lo;
    logic [ID_W-1:0] w_rr_win;
    logic            w_rr_found;

    always_comb begin
        w_rr_hi_found = 1'b0;
        w_rr_hi       = '0;
        w_rr_lo       = '0;
        for (int i = NUM_WAVEFRONTS - 1; i >= 0; i--) begin
            if (r_elig[i]) begin
                w_rr_lo = ID_W'(i);
                if (ID_W'(i) >= r_ptr) begin
                    w_rr_hi       = ID_W'(i);
                    w_rr_hi_found = 1'b1;
                end
            end
        end
    end

    assign w_rr_win   = w_rr_hi_found ? w_rr_hi : w_rr_lo;
    assign w_rr_found = |r_elig;

    // greedy max tree, two levels per step; left slot holds lower ids,
    // so it keeps ties
    logic           m_v  [SLOTS];
    logic [ID_W-1:0] m_id [SLOTS];
    logic [STAMP_W-1:0] m_st [SLOTS];
    logic           n_sv  [SLOTS];
    logic [ID_W-1:0] n_sid [SLOTS];
    logic [STAMP_W-1:0] n_sst [SLOTS];

    always_comb begin
        logic v_pick;
        for (int i = 0; i < SLOTS; i++) begin
            m_v[i]   = 1'b0;
            m_id[i]  = '0;
            m_st[i]  = '0;
            n_sv[i]  = 1'b0;
            n_sid[i] = '0;
            n_sst[i] = '0;
        end
        for (int k = 0; k < SLOTS / 2; k++) begin
            v_pick = r_sv[2*k+1] && (!r_sv[2*k] || (r_sst[2*k] < r_sst[2*k+1]));
            m_v[k]  = r_sv[2*k] | r_sv[2*k+1];
            m_id[k] = v_pick ? r_sid[2*k+1] : r_sid[2*k];
            m_st[k] = v_pick ? r_sst[2*k+1] : r_sst[2*k];
        end
        for (int k = 0; k < SLOTS / 2; k++) begin
            v_pick = m_v[2*k+1] && (!m_v[2*k] || (m_st[2*k] < m_st[2*k+1]));
            n_sv[k]  = m_v[2*k] | m_v[2*k+1];
            n_sid[k] = v_pick ? m_id[2*k+1] : m_id[2*k];
            n_sst[k] = v_pick ? m_st[2*k+1] : m_st[2*k];
        end
    end

    logic w_out_free;
    assign w_out_free = !r_out_valid || i_out_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= POL_RR;
            r_pool      <= '0;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_WAVEFRONTS; i++) begin
                r_stamp[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_data;
            end
            if (i_cmd.load_add && (32'(w_add_id) < NUM_WAVEFRONTS)) begin
                r_pool[ID_W'(w_add_id)] <= 1'b1;
            end
            if (i_cmd.load_sched) begin
                r_cnt <= '0;
            end else if (i_cmd.reduce) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.commit_rr && w_rr_found) begin
                r_pool[w_rr_win] <= 1'b0;
                r_ptr <= (w_rr_win == ID_W'(NUM_WAVEFRONTS - 1)) ? '0 : w_rr_win + 1'b1;
            end
            if (i_cmd.commit_gr && r_sv[0]) begin
                r_pool[r_sid[0]]  <= 1'b0;
                r_stamp[r_sid[0]] <= r_now;
            end
            if (i_cmd.commit_rr || i_cmd.commit_gr) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sched) begin
            r_elig <= w_elig;
            r_now  <= w_now;
            for (int i = 0; i < SLOTS; i++) begin
                r_sv[i]  <= w_elig_pad[i];
                r_sid[i] <= ID_W'(i);
                r_sst[i] <= w_stamp_pad[i];
            end
        end else if (i_cmd.reduce) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_sv[i]  <= n_sv[i];
                r_sid[i] <= n_sid[i];
                r_sst[i] <= n_sst[i];
            end
        end
        if (i_cmd.commit_rr) begin
            r_out_found <= w_rr_found;
            r_out_id    <= w_rr_found ? ID_OUT_W'(w_rr_win) : '0;
        end else if (i_cmd.commit_gr) begin
            r_out_found <= r_sv[0];
            r_out_id    <= r_sv[0] ? ID_OUT_W'(r_sid[0]) : '0;
        end
    end

    assign o_sts.in_valid    = i_in_valid;
    assign o_sts.in_mode     = i_in_mode;
    assign o_sts.policy      = r_policy;
    assign o_sts.out_free    = w_out_free;
    assign o_sts.reduce_last = (r_cnt == CNT_W'(STEPS - 1));

    assign o_out_valid = r_out_valid;
    assign o_out_found = r_out_found;
    assign o_out_id    = r_out_id;

endmodule

`default_nettype wire

// ===== src/wavefront_fetch_scheduler.sv =====
// wavefront_fetch_scheduler: top level, one word in, at most one result word out.
// Add word: taken in the idle state. Round-robin schedule: accept, then search/commit.
// Greedy schedule: accept, reduce steps, then commit; the reduce steps run on the
// shared max tree that resolves two levels per cycle. One word in flight at a time.
// Reset (i_rst_n low, synchronous): pool empty, pointer 0, stamps 0, policy round robin.
// Depends on wfs_pkg, wfs_ctrl, wfs_dp.
`default_nettype none

module wavefront_fetch_scheduler
    import wfs_pkg::*;
#(
    parameter int NUM_WAVEFRONTS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // config: policy register
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_data,

    // input stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [3:0] add_id, [19:4] running_mask, [35:20] fetch_busy_mask,
    // [67:36] cycle_now, [71:68] zero
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] mode (0 add, 1 schedule)
    input  wire logic                  i_s_axis_tuser,

    // result stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [3:0] chosen_id, [7:4] zero
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    // [0] found
    output logic                       o_m_axis_tuser
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic [ID_OUT_W-1:0] w_out_id;

    // Controller: idles with ready high; an add finishes at its accept edge,
    // a schedule walks the round-robin or greedy path and commits only when
    // the output register is free (empty or being drained this cycle).
    wfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Datapath: pool, pointer, stamps, the max tree and the result register.
    wfs_dp #(
        .NUM_WAVEFRONTS (NUM_WAVEFRONTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_mode   (i_s_axis_tuser),
        .i_in_data   (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_found (o_m_axis_tuser),
        .o_out_id    (w_out_id)
    );

    assign o_s_axis_tready = w_cmd.ready;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - ID_OUT_W){1'b0}}, w_out_id};

endmodule

`default_nettype wire

// ===== src/wfs_checker.sv =====
// wfs_checker: port-level assertions for wavefront_fetch_scheduler, plus its bind.
// Depends on wfs_pkg for the stream widths and item kinds.
`default_nettype none

module wfs_checker
    import wfs_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic                  i_s_axis_tuser,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input wire logic                  o_m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // no winner means id zero
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("nonzero id with found clear");

    // ready is low once a schedule word has been accepted
    a_sched_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == MODE_SCHED) |=>
            !o_s_axis_tready)
        else $error("ready high right after a schedule word");

    // an add word completes at its accept edge
    a_add_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == MODE_ADD) |=>
            o_s_axis_tready)
        else $error("ready dropped after an add word");

endmodule

bind wavefront_fetch_scheduler wfs_checker u_wfs_checker (.*);

`default_nettype wire
